FILE: rtl/core/imu_six_axis_block_averager_unit_assert.svh
// Assertion macros for the block averager.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef IMU_SIX_AXIS_BLOCK_AVERAGER_UNIT_ASSERT_SVH
`define IMU_SIX_AXIS_BLOCK_AVERAGER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define IMUSBA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define IMUSBA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) ante |=> cons) else $error(msg);
`else
`define IMUSBA_ASSERT(label, prop, msg)
`define IMUSBA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: rtl/core/imusba_pkg.sv
// Shared types and constants of the block averager.
// No dependencies; every other file but the assertion header imports this package.
package imusba_pkg;

   localparam int CHANNELS    = 6;
   localparam int RAW_W       = 16;
   localparam int SAMPLE_W    = 14;
   localparam int USED_W      = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   typedef struct packed {
      logic                               op;
      logic [CHANNELS-1:0][SAMPLE_W-1:0]  smp;
   } imusba_item_type;

   typedef struct packed {
      logic            valid;
      imusba_item_type item;
   } imusba_push_type;

endpackage

FILE: rtl/core/imusba_if.sv
// Valid/ready channel interfaces for the sample input and the average output.
// Depends on imusba_pkg.
interface imusba_req_if;
   import imusba_pkg::*;
   logic              valid;
   logic              ready;
   logic              op;
   logic [RAW_W-1:0]  gyro_x_raw;
   logic [RAW_W-1:0]  gyro_y_raw;
   logic [RAW_W-1:0]  gyro_z_raw;
   logic [RAW_W-1:0]  accel_x_raw;
   logic [RAW_W-1:0]  accel_y_raw;
   logic [RAW_W-1:0]  accel_z_raw;

   modport source (output valid, op, gyro_x_raw, gyro_y_raw, gyro_z_raw,
                   accel_x_raw, accel_y_raw, accel_z_raw, input ready);
   modport sink   (input valid, op, gyro_x_raw, gyro_y_raw, gyro_z_raw,
                   accel_x_raw, accel_y_raw, accel_z_raw, output ready);
endinterface

interface imusba_rsp_if;
   import imusba_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] gyro_x_avg;
   logic signed [SAMPLE_W-1:0] gyro_y_avg;
   logic signed [SAMPLE_W-1:0] gyro_z_avg;
   logic signed [SAMPLE_W-1:0] accel_x_avg;
   logic signed [SAMPLE_W-1:0] accel_y_avg;
   logic signed [SAMPLE_W-1:0] accel_z_avg;
   logic [USED_W-1:0]          samples_used;

   modport source (output valid, gyro_x_avg, gyro_y_avg, gyro_z_avg, accel_x_avg,
                   accel_y_avg, accel_z_avg, samples_used, input ready);
   modport sink   (input valid, gyro_x_avg, gyro_y_avg, gyro_z_avg, accel_x_avg,
                   accel_y_avg, accel_z_avg, samples_used, output ready);
endinterface

FILE: rtl/core/imusba_front.sv
// Front end: accepts input transfers, drops plain samples past the block limit.
// Depends on imusba_pkg and imusba_req_if.
module imusba_front #(
   parameter int BLOCK_LIMIT = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   imusba_req_if.sink                  req_chan,
   input  logic                        full,
   output imusba_pkg::imusba_push_type push
);
   import imusba_pkg::*;

   localparam int CNT_W = $clog2(BLOCK_LIMIT + 2);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept;
   logic             drop;

   assign req_chan.ready = !full && !reset;
   assign accept = req_chan.valid && req_chan.ready;
   assign drop   = (req_chan.op == OP_SAMPLE) && (count_ff >= CNT_W'(BLOCK_LIMIT));

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (req_chan.op == OP_REPORT) begin
            count_in = '0;
         end else if (!drop) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_comb begin
      push.valid       = accept && !drop;
      push.item.op     = req_chan.op;
      push.item.smp[0] = req_chan.gyro_x_raw[SAMPLE_W-1:0];
      push.item.smp[1] = req_chan.gyro_y_raw[SAMPLE_W-1:0];
      push.item.smp[2] = req_chan.gyro_z_raw[SAMPLE_W-1:0];
      push.item.smp[3] = req_chan.accel_x_raw[SAMPLE_W-1:0];
      push.item.smp[4] = req_chan.accel_y_raw[SAMPLE_W-1:0];
      push.item.smp[5] = req_chan.accel_z_raw[SAMPLE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

FILE: rtl/core/imusba_queue.sv
// Short FIFO between the front end and the accumulate/divide back end.
// Depends on imusba_pkg.
module imusba_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  imusba_pkg::imusba_push_type push,
   input  logic                        pop,
   output imusba_pkg::imusba_push_type head,
   output logic                        full
);
   import imusba_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

   imusba_item_type   mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0]  level_ff, level_in;
   logic              do_push;
   logic              do_pop;

   assign full    = (level_ff == LVL_W'(QUEUE_DEPTH));
   assign do_push = push.valid && !full;
   assign do_pop  = pop && (level_ff != '0);

   assign head.valid = (level_ff != '0);
   assign head.item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   level_in = level_ff + 1'b1;
         2'b01:   level_in = level_ff - 1'b1;
         default: level_in = level_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

FILE: rtl/core/imusba_back.sv
// Back end: per-channel sums, six parallel restoring dividers and the result register.
// Depends on imusba_pkg and imusba_rsp_if.
module imusba_back #(
   parameter int BLOCK_LIMIT = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  imusba_pkg::imusba_push_type head,
   output logic                        pop,
   imusba_rsp_if.source                rsp_chan
);
   import imusba_pkg::*;

   localparam int CNT_W  = $clog2(BLOCK_LIMIT + 2);
   localparam int SUM_W  = SAMPLE_W + CNT_W;
   localparam int STEP_W = $clog2(SUM_W);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_WAIT
   } state_type;

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CNT_W-1:0]           divisor_ff, divisor_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic signed [SUM_W-1:0]    sum_ff [CHANNELS];
   logic signed [SUM_W-1:0]    sum_in [CHANNELS];
   logic [SUM_W-1:0]           dvd_ff [CHANNELS];
   logic [SUM_W-1:0]           dvd_in [CHANNELS];
   logic [CNT_W-1:0]           rem_ff [CHANNELS];
   logic [CNT_W-1:0]           rem_in [CHANNELS];
   logic [CHANNELS-1:0]        neg_ff, neg_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] avg_ff [CHANNELS];
   logic signed [SAMPLE_W-1:0] avg_in [CHANNELS];
   logic [USED_W-1:0]          used_ff, used_in;

   logic signed [SUM_W-1:0]    sum_new [CHANNELS];
   logic [SUM_W-1:0]           mag_new [CHANNELS];
   logic [SUM_W-1:0]           dvd_next [CHANNELS];
   logic [CNT_W-1:0]           rem_next [CHANNELS];
   logic [SAMPLE_W-1:0]        avg_fin [CHANNELS];
   logic [CNT_W:0]             trial [CHANNELS];
   logic [CNT_W:0]             trial_sub [CHANNELS];
   logic [CHANNELS-1:0]        trial_ge;
   logic [CNT_W-1:0]           count_new;
   logic [USED_W+CNT_W-1:0]    used_ext;

   assign count_new = count_ff + 1'b1;
   assign used_ext  = {{USED_W{1'b0}}, divisor_ff};
   assign pop       = (state_ff == ST_IDLE) && head.valid;

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         sum_new[c] = sum_ff[c] + {{(SUM_W-SAMPLE_W){head.item.smp[c][SAMPLE_W-1]}},
                                   head.item.smp[c]};
         mag_new[c] = sum_new[c][SUM_W-1] ? SUM_W'(-sum_new[c]) : SUM_W'(sum_new[c]);
         trial[c]     = {rem_ff[c], dvd_ff[c][SUM_W-1]};
         trial_sub[c] = trial[c] - {1'b0, divisor_ff};
         trial_ge[c]  = (trial[c] >= {1'b0, divisor_ff});
         rem_next[c]  = trial_ge[c] ? trial_sub[c][CNT_W-1:0] : trial[c][CNT_W-1:0];
         dvd_next[c]  = {dvd_ff[c][SUM_W-2:0], trial_ge[c]};
         avg_fin[c]   = neg_ff[c] ? SAMPLE_W'(-dvd_ff[c][SAMPLE_W-1:0])
                                  : dvd_ff[c][SAMPLE_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      divisor_in   = divisor_ff;
      step_in      = step_ff;
      sum_in       = sum_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      avg_in       = avg_ff;
      used_in      = used_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               if (head.item.op == OP_REPORT) begin
                  for (int c = 0; c < CHANNELS; c++) begin
                     dvd_in[c] = mag_new[c];
                     neg_in[c] = sum_new[c][SUM_W-1];
                     rem_in[c] = '0;
                     sum_in[c] = '0;
                  end
                  divisor_in = count_new;
                  count_in   = '0;
                  step_in    = '0;
                  state_in   = ST_DIV;
               end else begin
                  sum_in   = sum_new;
                  count_in = count_new;
               end
            end
         end
         ST_DIV: begin
            dvd_in  = dvd_next;
            rem_in  = rem_next;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               for (int c = 0; c < CHANNELS; c++) begin
                  avg_in[c] = avg_fin[c];
               end
               used_in      = used_ext[USED_W-1:0];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            sum_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
      end
      divisor_ff <= divisor_in;
      step_ff    <= step_in;
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      neg_ff     <= neg_in;
      avg_ff     <= avg_in;
      used_ff    <= used_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.gyro_x_avg   = avg_ff[0];
   assign rsp_chan.gyro_y_avg   = avg_ff[1];
   assign rsp_chan.gyro_z_avg   = avg_ff[2];
   assign rsp_chan.accel_x_avg  = avg_ff[3];
   assign rsp_chan.accel_y_avg  = avg_ff[4];
   assign rsp_chan.accel_z_avg  = avg_ff[5];
   assign rsp_chan.samples_used = used_ff;

endmodule

FILE: rtl/core/imu_six_axis_block_averager_unit.sv
// Six-axis block averager: front end, two-entry queue, accumulate/divide back end.
// A plain sample is held in the queue before it reaches the sum registers; one per cycle is
// sustained while no report is in the back end. A report's result comes from the bit-serial
// restoring dividers; the back end takes no item while it divides or its result waits to go out.
// Synchronous reset clears the sums, the counts, the queue and the result valid.
`include "imu_six_axis_block_averager_unit_assert.svh"

module imu_six_axis_block_averager_unit #(
   parameter int BLOCK_LIMIT = 8
) (
   input  logic         clock,
   input  logic         reset,
   imusba_req_if.sink   req_chan,
   imusba_rsp_if.source rsp_chan
);
   import imusba_pkg::*;

   imusba_push_type push;
   imusba_push_type head;
   logic            full;
   logic            pop;
   logic            report_xfer;
   logic            report_pop;

   imusba_front #(
      .BLOCK_LIMIT (BLOCK_LIMIT)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .full     (full),
      .push     (push)
   );

   imusba_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (full)
   );

   imusba_back #(
      .BLOCK_LIMIT (BLOCK_LIMIT)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   assign report_xfer = req_chan.valid && req_chan.ready && (req_chan.op == OP_REPORT);
   assign report_pop  = pop && (head.item.op == OP_REPORT);

   `IMUSBA_ASSERT(a_no_overflow, push.valid |-> !full, "Push into a full queue.")
   `IMUSBA_ASSERT(a_pop_has_data, pop |-> head.valid, "Pop from an empty queue.")
   `IMUSBA_ASSERT(a_report_kept, report_xfer |-> push.valid, "Report transfer was dropped.")
   `IMUSBA_ASSERT_NEXT(a_report_blocks, report_pop, !pop, "Pop during division.")

endmodule

FILE: verif/imusba_average_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the six-axis block averager: watches both channels, keeps its own
// running sums and sample count, and checks every averaged result in arrival order.
// Depends on imusba_pkg and the channel interfaces in imusba_if.sv.
module imusba_average_checker #(
   parameter int BLOCK_LIMIT = 8
) (
   input  logic  clock,
   input  logic  reset,
   imusba_req_if req_mon,
   imusba_rsp_if rsp_mon,
   output int    failures,
   output int    averages_checked,
   output int    averages_pending
);
   import imusba_pkg::*;

   typedef struct packed {
      logic [CHANNELS-1:0][SAMPLE_W-1:0] avg;
      logic [USED_W-1:0]                 used;
   } block_average_type;

   string axis_label [CHANNELS] = '{"gyro_x", "gyro_y", "gyro_z",
                                    "accel_x", "accel_y", "accel_z"};

   int                running_sum [CHANNELS];
   int                running_count;
   block_average_type pending_averages [$];
   block_average_type observed;
   int                mismatch_count = 0;
   int                compared_count = 0;
   int                pending_count  = 0;

   assign failures         = mismatch_count;
   assign averages_checked = compared_count;
   assign averages_pending = pending_count;

   task automatic clear_block();
      for (int c = 0; c < CHANNELS; c++) begin
         running_sum[c] = 0;
      end
      running_count = 0;
   endtask

   task automatic fold_transfer(input logic op, input logic [CHANNELS-1:0][RAW_W-1:0] raw);
      block_average_type rec;
      int                value;
      int                quotient;
      if (op == OP_SAMPLE && running_count >= BLOCK_LIMIT) begin
         return;
      end
      for (int c = 0; c < CHANNELS; c++) begin
         value = $signed(raw[c][SAMPLE_W-1:0]);
         running_sum[c] += value;
      end
      running_count++;
      if (op == OP_REPORT) begin
         for (int c = 0; c < CHANNELS; c++) begin
            quotient = (running_count == 0) ? 0 : running_sum[c] / running_count;
            rec.avg[c] = quotient[SAMPLE_W-1:0];
         end
         rec.used = running_count[USED_W-1:0];
         pending_averages.push_back(rec);
         clear_block();
      end
   endtask

   task automatic check_result(input block_average_type got);
      block_average_type want;
      if (pending_averages.size() == 0) begin
         $display("%0t: average result with none expected (samples_used %0d)",
                  $time, got.used);
         mismatch_count++;
         return;
      end
      want = pending_averages.pop_front();
      for (int c = 0; c < CHANNELS; c++) begin
         if (got.avg[c] !== want.avg[c]) begin
            $display("%0t: %s_avg expected %0d, actual %0d", $time, axis_label[c],
                     $signed(want.avg[c]), $signed(got.avg[c]));
            mismatch_count++;
         end
      end
      if (got.used !== want.used) begin
         $display("%0t: samples_used expected %0d, actual %0d", $time, want.used, got.used);
         mismatch_count++;
      end
      compared_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_block();
         pending_averages.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            observed.avg  = {rsp_mon.accel_z_avg, rsp_mon.accel_y_avg, rsp_mon.accel_x_avg,
                             rsp_mon.gyro_z_avg, rsp_mon.gyro_y_avg, rsp_mon.gyro_x_avg};
            observed.used = rsp_mon.samples_used;
            check_result(observed);
         end
         if (req_mon.valid && req_mon.ready) begin
            fold_transfer(req_mon.op, {req_mon.accel_z_raw, req_mon.accel_y_raw,
                                       req_mon.accel_x_raw, req_mon.gyro_z_raw,
                                       req_mon.gyro_y_raw, req_mon.gyro_x_raw});
         end
      end
      pending_count = pending_averages.size();
   end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Top of the block averager test: clock, reset, sample stimulus and output back-pressure.
// Depends on imusba_pkg, imusba_if.sv, the averager RTL and imusba_average_checker.
module testbench;
   import imusba_pkg::*;

   localparam int AVG_LIMIT        = 8;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int HOLD_CYCLES      = 400;
   localparam int TAIL_CYCLES      = 40;
   localparam int RANDOM_PER_PHASE = 170;
   localparam int NOISE_PCT        = 8;

   typedef enum int {LEAN_TOP, LEAN_BOTTOM, LEAN_NONE} lean_type;

   logic clock = 1'b0;
   logic reset;
   logic hold_request = 1'b0;
   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   transfers_sent = 0;
   int   reports_sent = 0;
   int   useful_sent = 0;
   int   fill_level = 0;
   int   cycle_count = 0;
   int   failures;
   int   averages_checked;
   int   averages_pending;

   imusba_req_if req_chan ();
   imusba_rsp_if rsp_chan ();

   imu_six_axis_block_averager_unit #(
      .BLOCK_LIMIT(AVG_LIMIT)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   imusba_average_checker #(
      .BLOCK_LIMIT(AVG_LIMIT)
   ) checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .failures        (failures),
      .averages_checked(averages_checked),
      .averages_pending(averages_pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles, %0d averages outstanding.",
                  cycle_count, averages_pending);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // The long hold is counted here so the sender keeps offering while the output is blocked.
   initial begin : receiver
      int   hold_left;
      logic hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (hold_request && !hold_done) begin
            hold_left = HOLD_CYCLES - 1;
            hold_done = 1'b1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
         end
      end
   end

   task automatic offer(input logic op, input logic [CHANNELS-1:0][RAW_W-1:0] words);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.op          <= op;
      req_chan.gyro_x_raw  <= words[0];
      req_chan.gyro_y_raw  <= words[1];
      req_chan.gyro_z_raw  <= words[2];
      req_chan.accel_x_raw <= words[3];
      req_chan.accel_y_raw <= words[4];
      req_chan.accel_z_raw <= words[5];
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      transfers_sent++;
      if (op == OP_REPORT || fill_level < AVG_LIMIT) begin
         useful_sent++;
      end
      if (op == OP_REPORT) begin
         reports_sent++;
         fill_level = 0;
      end else if (fill_level < AVG_LIMIT) begin
         fill_level++;
      end
   endtask

   function automatic logic [RAW_W-1:0] raw_word(input lean_type lean);
      logic [RAW_W-1:0] w;
      w = RAW_W'($urandom_range(16'hFFFF, 0));
      case (lean)
         LEAN_TOP:    w[SAMPLE_W-1:0] = 14'h1FFF;
         LEAN_BOTTOM: w[SAMPLE_W-1:0] = 14'h2000;
         default:     ;
      endcase
      return w;
   endfunction

   // A block is a run of plain samples closed by a report; a few ops are flipped as noise.
   task automatic random_block();
      int                                depth;
      int                                pick;
      lean_type                          lean;
      logic                              op;
      logic [CHANNELS-1:0][RAW_W-1:0]    words;
      if ($urandom_range(3, 0) == 0) begin
         depth = $urandom_range(AVG_LIMIT + 4, AVG_LIMIT - 1);
      end else begin
         depth = $urandom_range(AVG_LIMIT - 1, 0);
      end
      pick = $urandom_range(5, 0);
      lean = (pick == 0) ? LEAN_TOP : (pick == 1) ? LEAN_BOTTOM : LEAN_NONE;
      for (int i = 0; i <= depth; i++) begin
         for (int c = 0; c < CHANNELS; c++) begin
            words[c] = raw_word(lean);
         end
         op = (i == depth) ? OP_REPORT : OP_SAMPLE;
         if ($urandom_range(99, 0) < NOISE_PCT) begin
            op = ($urandom_range(1, 0) == 1) ? OP_REPORT : OP_SAMPLE;
         end
         offer(op, words);
      end
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int quota);
      int target;
      target = useful_sent + quota;
      send_idle_pct  <= idle_pct;
      recv_stall_pct <= stall_pct;
      while (useful_sent < target) begin
         random_block();
      end
   endtask

   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.op          = OP_SAMPLE;
      req_chan.gyro_x_raw  = '0;
      req_chan.gyro_y_raw  = '0;
      req_chan.gyro_z_raw  = '0;
      req_chan.accel_x_raw = '0;
      req_chan.accel_y_raw = '0;
      req_chan.accel_z_raw = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      offer(OP_REPORT, {CHANNELS{16'h0000}});
      offer(OP_REPORT, {CHANNELS{16'hFFFF}});
      repeat (3) offer(OP_SAMPLE, {CHANNELS{16'h1FFF}});
      offer(OP_REPORT, {CHANNELS{16'hDFFF}});
      // A full block of most negative samples, two dropped samples, then a report at the limit.
      repeat (AVG_LIMIT) offer(OP_SAMPLE, {CHANNELS{16'h2000}});
      repeat (2) offer(OP_SAMPLE, {CHANNELS{16'h1FFF}});
      offer(OP_REPORT, {CHANNELS{16'hE000}});
      // A sum of minus one over two samples must truncate toward zero.
      offer(OP_SAMPLE, {CHANNELS{16'hC000}});
      offer(OP_REPORT, {CHANNELS{16'h3FFF}});
      offer(OP_SAMPLE, {16'h3FFE, 16'h0001, 16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555});
      offer(OP_REPORT, {16'h0002, 16'hFFFE, 16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA});

      run_phase(0, 0, RANDOM_PER_PHASE);
      run_phase(82, 0, RANDOM_PER_PHASE);
      run_phase(0, 82, RANDOM_PER_PHASE);
      run_phase(17, 17, RANDOM_PER_PHASE);
      hold_request <= 1'b1;
      run_phase(0, 0, 60);
      run_phase(0, 0, 40);

      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (averages_pending != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d sample transfers including %0d reports, through free-running,",
               transfers_sent, reports_sent);
      $display("sender-idle, receiver-stall, mixed and long output hold traffic;");
      $display("%0d averages checked.", averages_checked);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/imusba_pkg.sv
rtl/core/imusba_if.sv
rtl/core/imusba_front.sv
rtl/core/imusba_queue.sv
rtl/core/imusba_back.sv
rtl/core/imu_six_axis_block_averager_unit.sv
verif/imusba_average_checker.sv
verif/testbench.sv
